[rtl/core/cmc_pkg.sv]
`default_nettype none

package cmc_pkg;

  // Defaults for the top-level parameters.
  localparam int NUM_CLASSES_DEF = 16;
  localparam int COUNT_WIDTH_DEF = 32;

  // Fixed field widths.
  localparam int LABEL_W = 5;
  localparam int CMD_W   = 2;
  localparam int OUT_W   = 32;
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;

  // Register map: the register index is the word address, paddr[2].
  localparam logic REG_CLASSES_IN_USE = 1'b0;
  localparam logic [LABEL_W-1:0] CLASSES_RESET = 5'd16;

  typedef enum logic [CMD_W-1:0] {
    CMD_RECORD = 2'd0,
    CMD_READ   = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

endpackage : cmc_pkg

`default_nettype wire

[rtl/core/cmc_count_mem.sv]
`default_nettype none

// Counter memory with one synchronous read port and one write port.
// A per-entry valid bit makes entries not written since the last reset or
// clear read as zero, so a clear resets every entry at once.
module cmc_count_mem #(
  parameter int DEPTH = cmc_pkg::NUM_CLASSES_DEF,
  parameter int WIDTH = cmc_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     clr,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid;
  logic [WIDTH-1:0] rd_word;
  logic             rd_valid;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rd_word <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      valid <= '0;
    end else if (we) begin
      valid[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else if (rd_en) begin
      rd_valid <= valid[raddr] && !clr;
    end
  end

  assign rdata = rd_valid ? rd_word : '0;

endmodule : cmc_count_mem

`default_nettype wire

[rtl/core/confusion_matrix_counter_top.sv]
`default_nettype none

// One-vs-rest confusion matrix counters.
//
// Command channel: an item is accepted on a rising edge where start is high
// and busy is low. cmd selects record (count one predicted/true pair),
// read (return one class's four counts), clear (zero everything) or no-op.
// Labels are 1-based; a record with a label of zero, or above classes_in_use or
// NUM_CLASSES, is dropped, as are all records once the pair total has saturated.
//
// Result channel: a read produces exactly one item, shown on tp_count,
// tn_count, fp_count, fn_count and class_ok for the single cycle in which
// done is high. The receiver cannot stall, so it must take the item then.
// True negatives are computed on the fly as total minus the other three.
//
// Sequence: a counted record or a read first does a synchronous read of the
// counter memories at acceptance, then passes through ST_EXEC with busy high,
// where a record writes back its incremented counts and a read registers its
// result and done. Clear, no-op and a dropped record do not enter ST_EXEC
// and leave busy low.
//
// Reset (rst, synchronous) zeroes all counters through the memory valid
// bits, sets classes_in_use to 16 and returns to idle.
// classes_in_use is written through the APB port at byte address 0.
module confusion_matrix_counter_top #(
  parameter int NUM_CLASSES = cmc_pkg::NUM_CLASSES_DEF,
  parameter int COUNT_WIDTH = cmc_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // Configuration port
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [cmc_pkg::APB_AW-1:0]  paddr,
  input  wire logic [cmc_pkg::APB_DW-1:0]  pwdata,
  output logic      [cmc_pkg::APB_DW-1:0]  prdata,
  output logic                             pready,
  // Command channel
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [cmc_pkg::CMD_W-1:0]   cmd,
  input  wire logic [cmc_pkg::LABEL_W-1:0] found_class,
  input  wire logic [cmc_pkg::LABEL_W-1:0] true_class,
  input  wire logic [cmc_pkg::LABEL_W-1:0] read_class,
  // Result channel
  output logic                             done,
  output logic      [cmc_pkg::OUT_W-1:0]   tp_count,
  output logic      [cmc_pkg::OUT_W-1:0]   tn_count,
  output logic      [cmc_pkg::OUT_W-1:0]   fp_count,
  output logic      [cmc_pkg::OUT_W-1:0]   fn_count,
  output logic                             class_ok
);

  localparam int IDX_W = $clog2(NUM_CLASSES);
  localparam logic [8:0] NUM_CLASSES_LIM = 9'(NUM_CLASSES);

  // A label is valid when it is nonzero and within both the register limit
  // and the number of stored classes.
  function automatic logic label_valid(input logic [cmc_pkg::LABEL_W-1:0] label,
                                       input logic [cmc_pkg::LABEL_W-1:0] limit);
    return (label != '0) && (label <= limit) && (9'(label) <= NUM_CLASSES_LIM);
  endfunction

  // Configuration register.
  logic [cmc_pkg::LABEL_W-1:0] classes_in_use;
  logic                        cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == cmc_pkg::REG_CLASSES_IN_USE);

  always_ff @(posedge clk) begin
    if (rst) begin
      classes_in_use <= cmc_pkg::CLASSES_RESET;
    end else if (cfg_write) begin
      classes_in_use <= pwdata[cmc_pkg::LABEL_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == cmc_pkg::REG_CLASSES_IN_USE) begin
      prdata = cmc_pkg::APB_DW'(classes_in_use);
    end
  end

  // Command decode at acceptance.
  cmc_pkg::state_t state, state_next;
  cmc_pkg::cmd_t   cmd_in;
  logic            accept;
  logic            found_ok, exp_ok, rd_ok;
  logic            rec_go, rd_go, clr_go;
  logic [IDX_W-1:0] found_idx, exp_idx, rd_idx;
  logic [COUNT_WIDTH-1:0] total_pairs;

  assign cmd_in    = cmc_pkg::cmd_t'(cmd);
  assign accept    = start && !busy;
  assign found_ok  = label_valid(found_class, classes_in_use);
  assign exp_ok    = label_valid(true_class, classes_in_use);
  assign rd_ok     = label_valid(read_class, classes_in_use);
  assign found_idx = IDX_W'(5'(found_class - 5'd1));
  assign exp_idx   = IDX_W'(5'(true_class - 5'd1));
  assign rd_idx    = IDX_W'(5'(read_class - 5'd1));

  // A saturated total blocks further records, so no per-class counter can
  // wrap either.
  assign rec_go = accept && (cmd_in == cmc_pkg::CMD_RECORD) && found_ok && exp_ok &&
                  !(&total_pairs);
  assign rd_go  = accept && (cmd_in == cmc_pkg::CMD_READ);
  assign clr_go = accept && (cmd_in == cmc_pkg::CMD_CLEAR);

  // Operation context held for the ST_EXEC state.
  logic             op_read, op_match, op_ok;
  logic [IDX_W-1:0] op_found_idx, op_exp_idx;

  always_ff @(posedge clk) begin
    if (accept) begin
      op_read      <= (cmd_in == cmc_pkg::CMD_READ);
      op_match     <= (found_class == true_class);
      op_ok        <= rd_ok;
      op_found_idx <= found_idx;
      op_exp_idx   <= exp_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clr_go) begin
      total_pairs <= '0;
    end else if (rec_go) begin
      total_pairs <= total_pairs + 1'b1;
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cmc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  logic exec;

  always_comb begin
    state_next = state;
    busy       = 1'b0;
    exec       = 1'b0;
    case (state)
      cmc_pkg::ST_IDLE: begin
        if (rec_go || rd_go) begin
          state_next = cmc_pkg::ST_EXEC;
        end
      end
      cmc_pkg::ST_EXEC: begin
        busy       = 1'b1;
        exec       = 1'b1;
        state_next = cmc_pkg::ST_IDLE;
      end
      default: begin
        state_next = cmc_pkg::ST_IDLE;
      end
    endcase
  end

  // Counter memories: a read uses the read class on all three; a record
  // reads the predicted class in tp/fp and the true class in fn.
  logic [IDX_W-1:0]       tp_raddr, fn_raddr;
  logic [COUNT_WIDTH-1:0] tp_rd, fp_rd, fn_rd;
  logic                   tp_we, fp_we, fn_we;
  logic [COUNT_WIDTH-1:0] tn_diff;

  assign tp_raddr = (cmd_in == cmc_pkg::CMD_READ) ? rd_idx : found_idx;
  assign fn_raddr = (cmd_in == cmc_pkg::CMD_READ) ? rd_idx : exp_idx;

  assign tp_we = exec && !op_read && op_match;
  assign fp_we = exec && !op_read && !op_match;
  assign fn_we = exec && !op_read && !op_match;

  cmc_count_mem #(.DEPTH(NUM_CLASSES), .WIDTH(COUNT_WIDTH)) u_tp_mem (
    .clk   (clk),
    .rst   (rst),
    .clr   (clr_go),
    .rd_en (accept),
    .raddr (tp_raddr),
    .rdata (tp_rd),
    .we    (tp_we),
    .waddr (op_found_idx),
    .wdata (tp_rd + 1'b1)
  );

  cmc_count_mem #(.DEPTH(NUM_CLASSES), .WIDTH(COUNT_WIDTH)) u_fp_mem (
    .clk   (clk),
    .rst   (rst),
    .clr   (clr_go),
    .rd_en (accept),
    .raddr (tp_raddr),
    .rdata (fp_rd),
    .we    (fp_we),
    .waddr (op_found_idx),
    .wdata (fp_rd + 1'b1)
  );

  cmc_count_mem #(.DEPTH(NUM_CLASSES), .WIDTH(COUNT_WIDTH)) u_fn_mem (
    .clk   (clk),
    .rst   (rst),
    .clr   (clr_go),
    .rd_en (accept),
    .raddr (fn_raddr),
    .rdata (fn_rd),
    .we    (fn_we),
    .waddr (op_exp_idx),
    .wdata (fn_rd + 1'b1)
  );

  // Every pair adds exactly one of the four counts to each class, so the
  // true negatives follow from the total.
  assign tn_diff = total_pairs - tp_rd - fp_rd - fn_rd;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= exec && op_read;
    end
  end

  always_ff @(posedge clk) begin
    if (exec && op_read) begin
      class_ok <= op_ok;
      tp_count <= op_ok ? cmc_pkg::OUT_W'(tp_rd)   : '0;
      tn_count <= op_ok ? cmc_pkg::OUT_W'(tn_diff) : '0;
      fp_count <= op_ok ? cmc_pkg::OUT_W'(fp_rd)   : '0;
      fn_count <= op_ok ? cmc_pkg::OUT_W'(fn_rd)   : '0;
    end
  end

endmodule : confusion_matrix_counter_top

`default_nettype wire

[rtl/core/cmc_checker.sv]
`default_nettype none

module cmc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic [1:0]  cmd,
  input wire logic        done,
  input wire logic [31:0] tp_count,
  input wire logic [31:0] tn_count,
  input wire logic [31:0] fp_count,
  input wire logic [31:0] fn_count,
  input wire logic        class_ok
);

  logic accept;
  assign accept = start && !busy;

  // An accepted read is followed by busy and then by its result.
  a_read_result: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd == cmc_pkg::CMD_READ) |=> busy ##1 done)
    else $error("read item did not produce a result");

  // Record, clear and no-op items never produce a result.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd != cmc_pkg::CMD_READ) |=> ##1 !done)
    else $error("result without a read item");

  // Results never come back to back.
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for two cycles");

  // An invalid class reads as all-zero counts.
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !class_ok) |-> (tp_count == '0 && tn_count == '0 &&
                             fp_count == '0 && fn_count == '0))
    else $error("invalid class returned nonzero counts");

endmodule : cmc_checker

bind confusion_matrix_counter_top cmc_checker u_cmc_checker (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .busy     (busy),
  .cmd      (cmd),
  .done     (done),
  .tp_count (tp_count),
  .tn_count (tn_count),
  .fp_count (fp_count),
  .fn_count (fn_count),
  .class_ok (class_ok)
);

`default_nettype wire

[dv/confusion_matrix_checker.sv]
`timescale 1ns / 100ps

// Watches the command, result and configuration channels of the confusion
// matrix counter, keeps its own copy of the counters and checks every read.
module confusion_matrix_checker
  import cmc_pkg::*;
#(
  parameter int NUM_CLASSES = NUM_CLASSES_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [APB_DW-1:0]   pwdata,
  input  logic [APB_DW-1:0]   prdata,
  input  logic                pready,
  input  logic                start,
  input  logic                busy,
  input  logic [CMD_W-1:0]    cmd,
  input  logic [LABEL_W-1:0]  found_class,
  input  logic [LABEL_W-1:0]  true_class,
  input  logic [LABEL_W-1:0]  read_class,
  input  logic                done,
  input  logic [OUT_W-1:0]    tp_count,
  input  logic [OUT_W-1:0]    tn_count,
  input  logic [OUT_W-1:0]    fp_count,
  input  logic [OUT_W-1:0]    fn_count,
  input  logic                class_ok,
  output int                  fail_count,
  output int                  reads_outstanding
);

  typedef logic [COUNT_WIDTH-1:0] tally_t;

  typedef struct packed {
    logic [OUT_W-1:0] tp;
    logic [OUT_W-1:0] tn;
    logic [OUT_W-1:0] fp;
    logic [OUT_W-1:0] fn;
    logic             ok;
  } class_counts_t;

  tally_t             tp_tally [NUM_CLASSES];
  tally_t             fp_tally [NUM_CLASSES];
  tally_t             fn_tally [NUM_CLASSES];
  tally_t             pair_total;
  logic [LABEL_W-1:0] classes_cfg;
  class_counts_t      counts_due [$];

  function automatic bit label_valid(input logic [LABEL_W-1:0] label);
    int unsigned limit;
    limit = (classes_cfg < NUM_CLASSES) ? classes_cfg : NUM_CLASSES;
    return (label >= 1) && (label <= limit);
  endfunction

  function automatic void clear_tallies();
    for (int k = 0; k < NUM_CLASSES; k++) begin
      tp_tally[k] = '0;
      fp_tally[k] = '0;
      fn_tally[k] = '0;
    end
    pair_total = '0;
  endfunction

  // A pair with a bad label, or one arriving once the total is full, is lost.
  function automatic void tally_pair(input logic [LABEL_W-1:0] found,
                                     input logic [LABEL_W-1:0] truth);
    if (!label_valid(found) || !label_valid(truth) || pair_total == '1) return;
    pair_total++;
    if (found == truth) begin
      tp_tally[found - 1]++;
    end else begin
      fn_tally[truth - 1]++;
      fp_tally[found - 1]++;
    end
  endfunction

  function automatic class_counts_t class_counts(input logic [LABEL_W-1:0] cls);
    class_counts_t c;
    tally_t        t;
    tally_t        f;
    tally_t        n;
    tally_t        neg;
    c = '0;
    if (label_valid(cls)) begin
      t    = tp_tally[cls - 1];
      f    = fp_tally[cls - 1];
      n    = fn_tally[cls - 1];
      neg  = pair_total - t - f - n;
      c.tp = OUT_W'(t);
      c.tn = OUT_W'(neg);
      c.fp = OUT_W'(f);
      c.fn = OUT_W'(n);
      c.ok = 1'b1;
    end
    return c;
  endfunction

  task automatic check_field(input string field, input logic [OUT_W-1:0] want,
                             input logic [OUT_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    class_counts_t want;
    if (rst) begin
      clear_tallies();
      classes_cfg = CLASSES_RESET;
      counts_due.delete();
    end else begin
      if (psel && penable && pready && paddr[2] == REG_CLASSES_IN_USE) begin
        if (pwrite) begin
          classes_cfg = pwdata[LABEL_W-1:0];
        end else begin
          check_field("classes_in_use", OUT_W'(classes_cfg),
                      OUT_W'(prdata[LABEL_W-1:0]));
        end
      end
      // Results are checked before this edge's item is predicted, since an
      // item accepted now cannot have produced a result yet.
      if (done) begin
        if (counts_due.size() == 0) begin
          $error("read result arrived with no read outstanding");
          fail_count++;
        end else begin
          want = counts_due.pop_front();
          check_field("tp_count", want.tp, tp_count);
          check_field("tn_count", want.tn, tn_count);
          check_field("fp_count", want.fp, fp_count);
          check_field("fn_count", want.fn, fn_count);
          check_field("class_ok", OUT_W'(want.ok), OUT_W'(class_ok));
        end
      end
      if (start && !busy) begin
        case (cmd_t'(cmd))
          CMD_RECORD: tally_pair(found_class, true_class);
          CMD_READ:   counts_due.push_back(class_counts(read_class));
          CMD_CLEAR:  clear_tallies();
          default: ;
        endcase
      end
    end
    reads_outstanding = counts_due.size();
  end

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps

// Top of the confusion matrix counter bench. This module only produces the
// stimulus and gives the verdict; all prediction and comparison lives in the
// checker instantiated next to the block and in the assertions bound into it.
module testbench;
  import cmc_pkg::*;

  localparam int NUM_CLASSES = NUM_CLASSES_DEF;
  localparam int COUNT_WIDTH = COUNT_WIDTH_DEF;
  // Longest run of cycles with no handshake of any kind before we give up.
  // The longest legitimate quiet stretch is a sender gap at 69 percent idle.
  localparam int STALL_LIMIT = 2000;
  localparam int PHASES = 6;

  logic                clk = 1'b0;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [APB_AW-1:0]   paddr;
  logic [APB_DW-1:0]   pwdata;
  logic [APB_DW-1:0]   prdata;
  logic                pready;
  logic                start;
  logic                busy;
  logic [CMD_W-1:0]    cmd;
  logic [LABEL_W-1:0]  found_class;
  logic [LABEL_W-1:0]  true_class;
  logic [LABEL_W-1:0]  read_class;
  logic                done;
  logic [OUT_W-1:0]    tp_count;
  logic [OUT_W-1:0]    tn_count;
  logic [OUT_W-1:0]    fp_count;
  logic [OUT_W-1:0]    fn_count;
  logic                class_ok;
  int                  fail_count;
  int                  reads_outstanding;

  // Percentage of cycles in which the sender holds back an item.
  int idle_pct;
  // Number of labels the block currently accepts, given the last write of
  // classes_in_use. Used only to steer the random labels toward valid ones.
  int live_classes;
  int quiet_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  confusion_matrix_counter_top #(
    .NUM_CLASSES(NUM_CLASSES),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_dut (.*);

  confusion_matrix_checker #(
    .NUM_CLASSES(NUM_CLASSES),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_checker (.*);

  // Watchdog: any accepted item, result or register access counts as
  // progress. A long silence means the block has hung.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("confusion_matrix_counter_top test failed");
        $finish;
      end
    end
  end

  // Offer one item, after a random number of idle cycles, and return at the
  // edge where the block takes it. While idle, the payload is scrambled so
  // that nothing downstream can rely on stale fields.
  task automatic send(input cmd_t op, input logic [LABEL_W-1:0] found,
                      input logic [LABEL_W-1:0] truth,
                      input logic [LABEL_W-1:0] cls);
    while ($urandom_range(99) < idle_pct) begin
      start       <= 1'b0;
      cmd         <= CMD_W'($urandom);
      found_class <= LABEL_W'($urandom);
      true_class  <= LABEL_W'($urandom);
      read_class  <= LABEL_W'($urandom);
      @(posedge clk);
    end
    start       <= 1'b1;
    cmd         <= op;
    found_class <= found;
    true_class  <= truth;
    read_class  <= cls;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Stop offering items and wait until every read has been answered. A
  // record gives no result but keeps the block busy while it writes back, so
  // the task waits that out before the caller may touch the register.
  task automatic settle();
    start <= 1'b0;
    @(negedge clk);
    while (reads_outstanding != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write classes_in_use through the APB port, with junk in the unused upper
  // data bits, and read it straight back. The checker compares the readback.
  task automatic set_classes(input logic [LABEL_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_CLASSES_IN_USE, 2'b00};
    pwdata  <= {(APB_DW - LABEL_W)'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    live_classes = (value < NUM_CLASSES) ? value : NUM_CLASSES;
  endtask

  // Mostly a label the block will take; now and then any 5-bit value, which
  // covers zero, labels just above the limit and the top bit of the field.
  function automatic logic [LABEL_W-1:0] pick_label();
    if (live_classes > 0 && $urandom_range(99) < 85) begin
      return LABEL_W'($urandom_range(live_classes, 1));
    end
    return LABEL_W'($urandom_range(31, 0));
  endfunction

  // Random item: records dominate so the counters grow, reads follow them
  // closely, and clears are rare so that counts have time to build up. About
  // a third of the records are matching pairs to drive the true positives.
  task automatic random_item();
    cmd_t               op;
    int                 roll;
    logic [LABEL_W-1:0] found;
    logic [LABEL_W-1:0] truth;
    roll  = $urandom_range(99);
    found = pick_label();
    truth = ($urandom_range(9) < 3) ? found : pick_label();
    if (roll < 62) begin
      op = CMD_RECORD;
    end else if (roll < 92) begin
      op = CMD_READ;
    end else if (roll < 99) begin
      op = CMD_NOP;
    end else begin
      op = CMD_CLEAR;
    end
    send(op, found, truth, pick_label());
  endtask

  initial begin
    logic [LABEL_W-1:0] classes_plan [PHASES];
    int                 items_plan [PHASES];

    // Phase plan for classes_in_use: a narrow set, a value above the class
    // count (clamped to sixteen), zero (nothing valid, kept short), a single
    // class, something random, and finally back to the full sixteen. Each
    // shrink leaves the counters intact, so the reads that follow also check
    // that classes hidden and later exposed again keep their counts.
    classes_plan = '{5'd3, 5'd31, 5'd0, 5'd1, 5'd0, 5'd16};
    classes_plan[4] = LABEL_W'($urandom_range(15, 2));
    items_plan = '{380, 380, 60, 300, 380, 380};

    rst          = 1'b1;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    start        = 1'b0;
    cmd          = CMD_NOP;
    found_class  = '0;
    true_class   = '0;
    read_class   = '0;
    idle_pct     = 10;
    live_classes = NUM_CLASSES;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at the full class count.
    set_classes(CLASSES_RESET);
    // Fresh counters: every valid class reads zero; labels zero and 31 are
    // invalid and must read class_ok low.
    send(CMD_READ, 5'd0, 5'd0, 5'd1);
    send(CMD_READ, 5'd31, 5'd31, 5'd0);
    send(CMD_READ, 5'd0, 5'd31, 5'd31);
    send(CMD_READ, 5'd1, 5'd1, 5'd16);
    // Matches at both ends of the label range, then two mismatches.
    send(CMD_RECORD, 5'd1, 5'd1, 5'd0);
    send(CMD_RECORD, 5'd16, 5'd16, 5'd31);
    send(CMD_RECORD, 5'd3, 5'd7, 5'd0);
    send(CMD_RECORD, 5'd16, 5'd1, 5'd0);
    // Label zero or above the limit on either side: the pair is dropped.
    send(CMD_RECORD, 5'd0, 5'd5, 5'd0);
    send(CMD_RECORD, 5'd5, 5'd0, 5'd0);
    send(CMD_RECORD, 5'd17, 5'd2, 5'd0);
    send(CMD_RECORD, 5'd31, 5'd31, 5'd0);
    // The spare command code must do nothing, whatever its fields hold.
    send(CMD_NOP, 5'd2, 5'd2, 5'd2);
    send(CMD_READ, 5'd0, 5'd0, 5'd1);
    send(CMD_READ, 5'd0, 5'd0, 5'd3);
    send(CMD_READ, 5'd0, 5'd0, 5'd7);
    send(CMD_READ, 5'd0, 5'd0, 5'd16);
    send(CMD_READ, 5'd0, 5'd0, 5'd2);
    // Clear, then confirm everything reads zero and counting restarts.
    send(CMD_CLEAR, 5'd31, 5'd31, 5'd31);
    send(CMD_READ, 5'd0, 5'd0, 5'd1);
    send(CMD_READ, 5'd0, 5'd0, 5'd16);
    send(CMD_RECORD, 5'd2, 5'd2, 5'd0);
    send(CMD_READ, 5'd0, 5'd0, 5'd2);

    // Random phases. The sender idles in 10 percent of cycles for the first
    // two, 69 percent for the next two, and never for the last two.
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      idle_pct = (ph < 2) ? 10 : (ph < 4) ? 69 : 0;
      set_classes(classes_plan[ph]);
      repeat (items_plan[ph]) random_item();
    end

    // Drain the last reads, give any trailing record time to finish, then
    // judge on the checker's count.
    start <= 1'b0;
    @(negedge clk);
    while (reads_outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    if (fail_count == 0) begin
      $display("confusion_matrix_counter_top test passed");
    end else begin
      $display("confusion_matrix_counter_top test failed");
    end
    $finish;
  end

endmodule

[confusion_matrix_counter_top.f]
rtl/core/cmc_pkg.sv
rtl/core/cmc_count_mem.sv
rtl/core/confusion_matrix_counter_top.sv
rtl/core/cmc_checker.sv
dv/confusion_matrix_checker.sv
dv/testbench.sv
